[rtl/aagg_pkg.sv]
`timescale 1ns / 1ps

package aagg_pkg;

  // class count default, carried as a top-level parameter
  localparam int NUM_CLASSES_DEF = 8;

  // fixed framing constants
  localparam int WLAN_HDR_MAX  = 36;
  localparam int MIN_AGG_COUNT = 4;
  localparam int LEN_STEP      = 256;
  localparam int SUBHDR_BYTES  = 14;
  localparam int LLC_BYTES     = 6;

  // field widths
  localparam int TID_W    = 3;
  localparam int LEN_W    = 14;
  localparam int SEC_W    = 6;
  localparam int PAD_W    = 2;
  localparam int CNT_W    = 4;
  localparam int COST_W   = LEN_W + 1;
  localparam int LIM_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 14;

  localparam logic [LEN_W-1:0] LEN_MAX         = {LEN_W{1'b1}};
  localparam logic [LEN_W-1:0] MAX_MPDU_RESET  = 14'd3839;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_MPDU_LEN = 2'd0,
    CFG_MAX_SUBFRAMES = 2'd1,
    CFG_MESH_MODE = 2'd2
  } cfg_idx_e;

  // decision codes
  typedef enum logic [1:0] {
    DEC_SKIP   = 2'd0,
    DEC_ANCHOR = 2'd1,
    DEC_SUB    = 2'd2
  } decision_e;

  typedef struct packed {
    logic [LEN_W-1:0] max_mpdu_len;
    logic [CNT_W-1:0] max_subframes;
    logic             mesh_mode;
  } cfg_t;

  typedef struct packed {
    logic [TID_W-1:0] traffic_id;
    logic [LEN_W-1:0] frame_len;
    logic             llc_needed;
    logic [SEC_W-1:0] security_overhead;
    logic [PAD_W-1:0] align_pads;
  } pkt_t;

  typedef struct packed {
    logic [LEN_W-1:0] budget;
    logic [CNT_W-1:0] count;
    logic             open;
  } class_state_t;

  typedef struct packed {
    decision_e        decision;
    logic [CNT_W-1:0] slot;
    logic [LEN_W-1:0] status_bytes;
    logic             closed;
  } result_t;

endpackage

[rtl/aagg_cfg.sv]
`timescale 1ns / 1ps

module aagg_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [aagg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [aagg_pkg::CFG_DAT_W-1:0] cfg_data_i,
  output aagg_pkg::cfg_t                 cfg_o
);
  import aagg_pkg::*;

  cfg_t cfg_q, cfg_d;

  // registers always take a write
  assign cfg_ready_o = 1'b1;

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_MPDU_LEN:  cfg_d.max_mpdu_len  = cfg_data_i[LEN_W-1:0];
        CFG_MAX_SUBFRAMES: cfg_d.max_subframes = cfg_data_i[CNT_W-1:0];
        CFG_MESH_MODE:     cfg_d.mesh_mode     = cfg_data_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_mpdu_len  <= MAX_MPDU_RESET;
      cfg_q.max_subframes <= '0;
      cfg_q.mesh_mode     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/aagg_state.sv]
`timescale 1ns / 1ps

module aagg_state #(
  parameter int NUM_CLASSES = aagg_pkg::NUM_CLASSES_DEF,
  parameter int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [CLS_W-1:0]       rd_idx_i,
  output aagg_pkg::class_state_t rd_data_o,
  input  logic                   wr_en_i,
  input  logic [CLS_W-1:0]       wr_idx_i,
  input  aagg_pkg::class_state_t wr_data_i
);
  import aagg_pkg::*;

  class_state_t ent_q [NUM_CLASSES];

  // per-class anchor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        ent_q[i] <= '0;
      end
    end else if (wr_en_i && (int'(wr_idx_i) < NUM_CLASSES)) begin
      ent_q[wr_idx_i] <= wr_data_i;
    end
  end

  // read port, out-of-range reads give an idle entry
  always_comb begin
    if (int'(rd_idx_i) < NUM_CLASSES) begin
      rd_data_o = ent_q[rd_idx_i];
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

[rtl/aagg_decide.sv]
`timescale 1ns / 1ps

module aagg_decide (
  input  aagg_pkg::cfg_t         cfg_i,
  input  aagg_pkg::pkt_t         pkt_i,
  input  logic                   cls_valid_i,
  input  aagg_pkg::class_state_t cur_i,
  output logic                   wr_en_o,
  output aagg_pkg::class_state_t nxt_o,
  output aagg_pkg::result_t      res_o
);
  import aagg_pkg::*;

  logic              refuse;
  logic              join_ok;
  logic [COST_W-1:0] anchor_cost;
  logic [COST_W-1:0] sub_cost;
  logic [COST_W-1:0] status_sum;
  logic [LEN_W-1:0]  anchor_budget;
  logic [LEN_W-1:0]  sub_budget;
  logic [LEN_W-1:0]  cur_len;
  logic [COST_W-1:0] new_len;
  logic [CNT_W:0]    cnt_inc;
  logic [LIM_W-1:0]  len_limit;
  logic              short_agg;
  logic [COST_W-1:0] llc_bytes;

  // cost and budget arithmetic
  always_comb begin
    llc_bytes   = pkt_i.llc_needed ? COST_W'(LLC_BYTES) : '0;
    anchor_cost = COST_W'(pkt_i.frame_len) + COST_W'(WLAN_HDR_MAX)
                  + COST_W'(pkt_i.security_overhead) + llc_bytes;
    sub_cost    = COST_W'(pkt_i.frame_len) + COST_W'(pkt_i.align_pads) + llc_bytes;

    anchor_budget = (COST_W'(cfg_i.max_mpdu_len) > anchor_cost)
                    ? cfg_i.max_mpdu_len - anchor_cost[LEN_W-1:0] : '0;
    sub_budget    = (COST_W'(cur_i.budget) > sub_cost)
                    ? cur_i.budget - sub_cost[LEN_W-1:0] : '0;

    cur_len   = (cfg_i.max_mpdu_len > cur_i.budget)
                ? cfg_i.max_mpdu_len - cur_i.budget : '0;
    new_len   = COST_W'(cur_len) + COST_W'(pkt_i.frame_len);
    cnt_inc   = {1'b0, cur_i.count} + (CNT_W+1)'(1);
    len_limit = LIM_W'(cnt_inc) * LIM_W'(LEN_STEP);
    short_agg = (cur_i.count >= CNT_W'(MIN_AGG_COUNT))
                && (LIM_W'(new_len) < len_limit);

    status_sum = sub_cost + ((cnt_inc == (CNT_W+1)'(2)) ? COST_W'(SUBHDR_BYTES) : '0);

    refuse  = (pkt_i.frame_len > cfg_i.max_mpdu_len) || cfg_i.mesh_mode;
    join_ok = (cur_i.budget > pkt_i.frame_len)
              && (cur_i.count < cfg_i.max_subframes) && !cfg_i.mesh_mode;
  end

  // admission decision and state update
  always_comb begin
    wr_en_o = 1'b0;
    nxt_o   = cur_i;
    res_o.decision     = DEC_SKIP;
    res_o.slot         = '0;
    res_o.status_bytes = '0;
    res_o.closed       = 1'b0;

    if (cls_valid_i) begin
      if (!cur_i.open) begin
        // no anchor yet
        if (!refuse) begin
          wr_en_o        = 1'b1;
          nxt_o.budget   = anchor_budget;
          nxt_o.count    = CNT_W'(1);
          nxt_o.open     = 1'b1;
          res_o.decision = DEC_ANCHOR;
        end
      end else if (join_ok && short_agg) begin
        // aggregate too thin for its count, start over
        wr_en_o        = 1'b1;
        nxt_o.budget   = anchor_budget;
        nxt_o.count    = CNT_W'(1);
        nxt_o.open     = 1'b1;
        res_o.decision = DEC_ANCHOR;
        res_o.closed   = 1'b1;
      end else if (join_ok) begin
        // join as a sub-frame
        wr_en_o            = 1'b1;
        nxt_o.budget       = sub_budget;
        nxt_o.count        = cnt_inc[CNT_W-1:0];
        res_o.decision     = DEC_SUB;
        res_o.slot         = cur_i.count;
        res_o.status_bytes = (status_sum > COST_W'(LEN_MAX)) ? LEN_MAX
                             : status_sum[LEN_W-1:0];
        if (cnt_inc >= {1'b0, cfg_i.max_subframes}) begin
          nxt_o.budget = cfg_i.max_mpdu_len;
          nxt_o.count  = '0;
          nxt_o.open   = 1'b0;
          res_o.closed = 1'b1;
        end
      end else if (refuse) begin
        // close and skip
        wr_en_o      = 1'b1;
        nxt_o.budget = cfg_i.max_mpdu_len;
        nxt_o.count  = '0;
        nxt_o.open   = 1'b0;
        res_o.closed = 1'b1;
      end else begin
        // replace the anchor
        wr_en_o        = 1'b1;
        nxt_o.budget   = anchor_budget;
        nxt_o.count    = CNT_W'(1);
        nxt_o.open     = 1'b1;
        res_o.decision = DEC_ANCHOR;
        res_o.closed   = 1'b1;
      end
    end
  end

endmodule

[rtl/amsdu_aggregation_admit_core.sv]
`timescale 1ns / 1ps

// result: a transferred packet passes the input register and the result register;
//   done_o is high for one cycle with its result; the receiver cannot stall
// throughput: one packet per cycle; busy_o stays low, the per-class anchor
//   read-modify-write completes in the single decision stage
// reset: rst_ni low clears all anchors (closed, zero budget and count) and the
//   pipeline valid flags, and loads the register reset values; no clearing pass
module amsdu_aggregation_admit_core #(
  parameter int NUM_CLASSES = aagg_pkg::NUM_CLASSES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [aagg_pkg::TID_W-1:0]     traffic_id_i,
  input  logic [aagg_pkg::LEN_W-1:0]     frame_len_i,
  input  logic                           llc_needed_i,
  input  logic [aagg_pkg::SEC_W-1:0]     security_overhead_i,
  input  logic [aagg_pkg::PAD_W-1:0]     align_pads_i,
  output logic                           done_o,
  output logic [1:0]                     decision_o,
  output logic [aagg_pkg::CNT_W-1:0]     subframe_slot_o,
  output logic [aagg_pkg::LEN_W-1:0]     status_bytes_added_o,
  output logic                           anchor_closed_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [aagg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [aagg_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import aagg_pkg::*;

  localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  cfg_t         cfg;
  pkt_t         pkt_q, pkt_d;
  logic         in_valid_q, in_valid_d;
  logic         accept;
  logic         cls_valid;
  logic [CLS_W-1:0] cls_idx;
  class_state_t cur_ent;
  class_state_t nxt_ent;
  logic         wr_en;
  result_t      res;
  result_t      res_q;
  logic         done_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // input register
  always_comb begin
    in_valid_d             = accept;
    pkt_d.traffic_id       = traffic_id_i;
    pkt_d.frame_len        = frame_len_i;
    pkt_d.llc_needed       = llc_needed_i;
    pkt_d.security_overhead = security_overhead_i;
    pkt_d.align_pads       = align_pads_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pkt_q <= pkt_d;
    end
  end

  // class select
  assign cls_idx   = CLS_W'(pkt_q.traffic_id);
  assign cls_valid = in_valid_q && (int'(pkt_q.traffic_id) < NUM_CLASSES);

  aagg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  aagg_state #(
    .NUM_CLASSES (NUM_CLASSES),
    .CLS_W       (CLS_W)
  ) u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (cls_idx),
    .rd_data_o (cur_ent),
    .wr_en_i   (wr_en),
    .wr_idx_i  (cls_idx),
    .wr_data_i (nxt_ent)
  );

  aagg_decide u_decide (
    .cfg_i       (cfg),
    .pkt_i       (pkt_q),
    .cls_valid_i (cls_valid),
    .cur_i       (cur_ent),
    .wr_en_o     (wr_en),
    .nxt_o       (nxt_ent),
    .res_o       (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      res_q <= res;
    end
  end

  assign done_o               = done_q;
  assign decision_o           = 2'(res_q.decision);
  assign subframe_slot_o      = res_q.slot;
  assign status_bytes_added_o = res_q.status_bytes;
  assign anchor_closed_o      = res_q.closed;

endmodule

[test/tb_amsdu_aggregation_admit_core.sv]
`timescale 1ns / 1ps

module tb_amsdu_aggregation_admit_core;
  import aagg_pkg::*;

  localparam int NUM_TID = NUM_CLASSES_DEF;

  // dut ports
  logic                 clk_i               = 1'b0;
  logic                 rst_ni              = 1'b0;
  logic                 start_i             = 1'b0;
  logic                 busy_o;
  logic [TID_W-1:0]     traffic_id_i        = '0;
  logic [LEN_W-1:0]     frame_len_i         = '0;
  logic                 llc_needed_i        = 1'b0;
  logic [SEC_W-1:0]     security_overhead_i = '0;
  logic [PAD_W-1:0]     align_pads_i        = '0;
  logic                 done_o;
  logic [1:0]           decision_o;
  logic [CNT_W-1:0]     subframe_slot_o;
  logic [LEN_W-1:0]     status_bytes_added_o;
  logic                 anchor_closed_o;
  logic                 cfg_valid_i         = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i         = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i          = '0;

  amsdu_aggregation_admit_core dut (.*);

  // planned traffic: packets, register writes and drain points
  typedef enum {PLAN_PKT, PLAN_CFG, PLAN_DRAIN} plan_kind_e;

  typedef struct {
    plan_kind_e           kind;
    pkt_t                 pkt;
    int unsigned          gap;
    cfg_idx_e             idx;
    logic [CFG_DAT_W-1:0] data;
  } plan_t;

  plan_t       traffic_plan_q[$];
  result_t     decision_q[$];
  int unsigned fault_count = 0;
  bit          pkt_taken   = 1'b0;
  bit          cfg_taken   = 1'b0;
  bit          gap_armed   = 1'b0;
  int unsigned idle_left   = 0;

  // shadow of the per-class anchors and the registers
  logic [LEN_W-1:0] anchor_budget [NUM_TID] = '{default: '0};
  logic [CNT_W-1:0] anchor_count  [NUM_TID] = '{default: '0};
  logic             anchor_live   [NUM_TID] = '{default: 1'b0};
  int unsigned      mpdu_limit     = MAX_MPDU_RESET;
  int unsigned      subframe_limit = 0;
  bit               mesh_on        = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // start a fresh anchor with this packet as its first frame
  function automatic void open_anchor(int unsigned c, pkt_t p);
    int unsigned cost;
    cost = p.frame_len + WLAN_HDR_MAX + p.security_overhead + (p.llc_needed ? LLC_BYTES : 0);
    anchor_budget[c] = LEN_W'((mpdu_limit > cost) ? mpdu_limit - cost : 0);
    anchor_count[c]  = CNT_W'(1);
    anchor_live[c]   = 1'b1;
  endfunction

  function automatic void close_anchor(int unsigned c);
    anchor_budget[c] = LEN_W'(mpdu_limit);
    anchor_count[c]  = '0;
    anchor_live[c]   = 1'b0;
  endfunction

  // decision for one packet, updating the shadow anchors
  function automatic result_t admit_packet(pkt_t p);
    result_t     r;
    int unsigned c, len, rem, cnt, cur, cost;
    bit          refuse;
    r.decision     = DEC_SKIP;
    r.slot         = '0;
    r.status_bytes = '0;
    r.closed       = 1'b0;
    c      = p.traffic_id;
    len    = p.frame_len;
    refuse = (len > mpdu_limit) || mesh_on;
    if (!anchor_live[c]) begin
      if (!refuse) begin
        open_anchor(c, p);
        r.decision = DEC_ANCHOR;
      end
    end else begin
      cnt = anchor_count[c];
      rem = anchor_budget[c];
      if (rem > len && cnt < subframe_limit && !mesh_on) begin
        // a budget above the limit means an empty aggregate so far
        cur = (mpdu_limit > rem) ? mpdu_limit - rem : 0;
        if (cnt >= MIN_AGG_COUNT && cur + len < (cnt + 1) * LEN_STEP) begin
          open_anchor(c, p);
          r.decision = DEC_ANCHOR;
          r.closed   = 1'b1;
        end else begin
          cost = len + p.align_pads + (p.llc_needed ? LLC_BYTES : 0);
          anchor_budget[c] = LEN_W'((rem > cost) ? rem - cost : 0);
          anchor_count[c]  = CNT_W'(cnt + 1);
          if (cnt + 1 == 2) cost += SUBHDR_BYTES;
          r.status_bytes = (cost > LEN_MAX) ? LEN_MAX : LEN_W'(cost);
          r.slot         = CNT_W'(cnt);
          r.decision     = DEC_SUB;
          if (cnt + 1 >= subframe_limit) begin
            close_anchor(c);
            r.closed = 1'b1;
          end
        end
      end else if (refuse) begin
        close_anchor(c);
        r.closed = 1'b1;
      end else begin
        open_anchor(c, p);
        r.decision = DEC_ANCHOR;
        r.closed   = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      fault_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  task automatic plan_pkt(int unsigned tid, int unsigned len, bit llc, int unsigned sec,
                          int unsigned pads, int unsigned gap);
    plan_t e;
    e.kind                  = PLAN_PKT;
    e.pkt.traffic_id        = TID_W'(tid);
    e.pkt.frame_len         = LEN_W'(len);
    e.pkt.llc_needed        = llc;
    e.pkt.security_overhead = SEC_W'(sec);
    e.pkt.align_pads        = PAD_W'(pads);
    e.gap                   = gap;
    e.idx                   = CFG_MAX_MPDU_LEN;
    e.data                  = '0;
    traffic_plan_q.push_back(e);
  endtask

  task automatic plan_cfg(cfg_idx_e idx, int unsigned value);
    plan_t e;
    e.kind = PLAN_CFG;
    e.pkt  = '0;
    e.gap  = 0;
    e.idx  = idx;
    e.data = CFG_DAT_W'(value);
    traffic_plan_q.push_back(e);
  endtask

  task automatic plan_drain();
    plan_t e;
    e.kind = PLAN_DRAIN;
    e.pkt  = '0;
    e.gap  = 0;
    e.idx  = CFG_MAX_MPDU_LEN;
    e.data = '0;
    traffic_plan_q.push_back(e);
  endtask

  // driver: packet and register transfers, changed on the falling edge
  always @(negedge clk_i) begin
    logic  start_n;
    logic  cfg_valid_n;
    plan_t head;
    start_n     = start_i;
    cfg_valid_n = cfg_valid_i;
    if (pkt_taken) start_n = 1'b0;
    if (cfg_taken) cfg_valid_n = 1'b0;
    pkt_taken = 1'b0;
    cfg_taken = 1'b0;
    if (rst_ni && !start_n && !cfg_valid_n && traffic_plan_q.size() != 0) begin
      head = traffic_plan_q[0];
      case (head.kind)
        PLAN_PKT: begin
          if (!gap_armed) begin
            idle_left = head.gap;
            gap_armed = 1'b1;
          end
          if (idle_left != 0) begin
            idle_left--;
          end else begin
            void'(traffic_plan_q.pop_front());
            gap_armed            = 1'b0;
            traffic_id_i        <= head.pkt.traffic_id;
            frame_len_i         <= head.pkt.frame_len;
            llc_needed_i        <= head.pkt.llc_needed;
            security_overhead_i <= head.pkt.security_overhead;
            align_pads_i        <= head.pkt.align_pads;
            start_n              = 1'b1;
          end
        end
        // register writes only once every decision is back
        PLAN_CFG: begin
          if (decision_q.size() == 0) begin
            void'(traffic_plan_q.pop_front());
            cfg_index_i <= head.idx;
            cfg_data_i  <= head.data;
            cfg_valid_n  = 1'b1;
          end
        end
        PLAN_DRAIN: begin
          if (decision_q.size() == 0) void'(traffic_plan_q.pop_front());
        end
        default: ;
      endcase
    end
    start_i     <= start_n;
    cfg_valid_i <= cfg_valid_n;
  end

  // monitor: check results, then record transfers taken at this edge
  always @(posedge clk_i) begin
    result_t want;
    pkt_t    seen;
    if (rst_ni) begin
      if (done_o) begin
        if (decision_q.size() == 0) begin
          fault_count++;
          $display("%0t: result with no packet pending, actual decision %0d", $time,
                   decision_o);
        end else begin
          want = decision_q.pop_front();
          check_field("decision", want.decision, decision_o);
          check_field("subframe_slot", want.slot, subframe_slot_o);
          check_field("status_bytes_added", want.status_bytes, status_bytes_added_o);
          check_field("anchor_closed", want.closed, anchor_closed_o);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_taken = 1'b1;
        case (cfg_idx_e'(cfg_index_i))
          CFG_MAX_MPDU_LEN:  mpdu_limit     = cfg_data_i;
          CFG_MAX_SUBFRAMES: subframe_limit = cfg_data_i[CNT_W-1:0];
          CFG_MESH_MODE:     mesh_on        = cfg_data_i[0];
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        pkt_taken              = 1'b1;
        seen.traffic_id        = traffic_id_i;
        seen.frame_len         = frame_len_i;
        seen.llc_needed        = llc_needed_i;
        seen.security_overhead = security_overhead_i;
        seen.align_pads        = align_pads_i;
        decision_q.push_back(admit_packet(seen));
      end
    end
  end

  initial begin
    int unsigned made, phase_len, hot_a, hot_b, r, mpdu, len, tid, gap;
    bit          burst;

    // directed: reset settings, joins impossible while max_subframes is zero
    plan_pkt(0, 0, 0, 0, 0, 0);
    plan_pkt(0, 100, 1, 8, 1, 1);
    plan_pkt(1, LEN_MAX, 1, 63, 3, 0);
    plan_pkt(0, LEN_MAX, 0, 0, 0, 2);
    plan_cfg(CFG_MAX_SUBFRAMES, 15);
    // anchor that eats the whole budget, then a zero-length follower
    plan_pkt(2, MAX_MPDU_RESET, 1, 63, 3, 0);
    plan_pkt(2, 0, 0, 0, 0, 0);
    // chain of joins until the length-per-count rule opens a new anchor
    plan_pkt(3, 10, 0, 0, 0, 0);
    repeat (4) plan_pkt(3, 100, 0, 0, 0, 0);
    plan_pkt(3, 1000, 1, 20, 3, 3);
    // count limit reached by a join closes the anchor
    plan_cfg(CFG_MAX_SUBFRAMES, 2);
    plan_pkt(4, 500, 1, 0, 2, 0);
    plan_pkt(4, 500, 1, 0, 2, 0);
    // mesh mode refuses everything
    plan_cfg(CFG_MESH_MODE, 1);
    plan_pkt(5, 5, 0, 0, 0, 0);
    plan_pkt(3, 5, 0, 0, 0, 1);
    plan_cfg(CFG_MESH_MODE, 0);
    // zero budget limit
    plan_cfg(CFG_MAX_MPDU_LEN, 0);
    plan_pkt(6, 0, 0, 0, 0, 0);
    plan_pkt(6, 1, 0, 0, 0, 0);
    // budget left above a lowered limit
    plan_cfg(CFG_MAX_MPDU_LEN, 11454);
    plan_cfg(CFG_MAX_SUBFRAMES, 15);
    plan_pkt(7, 50, 0, 0, 0, 0);
    plan_cfg(CFG_MAX_MPDU_LEN, 1000);
    plan_pkt(7, 200, 0, 0, 1, 0);
    plan_pkt(7, LEN_MAX, 1, 63, 3, 0);

    // random phases, each with fresh settings and a couple of busy classes
    made = 0;
    while (made < 1800) begin
      r    = $urandom_range(0, 99);
      mpdu = (r < 5) ? 0 : (r < 25) ? 11454 : (r < 45) ? 3839 : $urandom_range(0, 11454);
      plan_cfg(CFG_MAX_MPDU_LEN, mpdu);
      r = $urandom_range(0, 99);
      plan_cfg(CFG_MAX_SUBFRAMES, (r < 10) ? 0 : (r < 35) ? 15 : $urandom_range(1, 15));
      plan_cfg(CFG_MESH_MODE, ($urandom_range(0, 99) < 12) ? 1 : 0);
      burst     = ($urandom_range(0, 3) == 0);
      hot_a     = $urandom_range(0, NUM_TID - 1);
      hot_b     = $urandom_range(0, NUM_TID - 1);
      phase_len = $urandom_range(40, 160);
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        if (r < 55)      len = $urandom_range(0, 300);
        else if (r < 80) len = $urandom_range(0, 2000);
        else if (r < 92) len = $urandom_range(0, mpdu);
        else             len = $urandom_range(0, LEN_MAX);
        if ($urandom_range(0, 9) < 8) tid = $urandom_range(0, 1) ? hot_a : hot_b;
        else                          tid = $urandom_range(0, NUM_TID - 1);
        r = $urandom_range(0, 99);
        if (burst || r < 60) gap = 0;
        else if (r < 88)     gap = $urandom_range(1, 3);
        else if (r < 97)     gap = $urandom_range(4, 12);
        else                 gap = $urandom_range(20, 60);
        plan_pkt(tid, len, ($urandom_range(0, 1) == 1), $urandom_range(0, 63),
                 $urandom_range(0, 3), gap);
        // sender holds off until every decision is back
        if ($urandom_range(0, 99) == 0) plan_drain();
        made++;
      end
    end

    // reset once, released away from the sampling edge
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (traffic_plan_q.size() != 0 || start_i || cfg_valid_i || decision_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
